FILE: rtl/core/mtdp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mtdp_pkg;

  localparam int ROUNDS = 64;

  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;

  // fixed text after the MAC digits, first character in the top byte
  localparam logic [303:0] TAIL = "555043444541554C5450415353504852415345";

  localparam logic [31:0] MD5_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam int MD5_R [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

  function automatic int md5_shift(int r);
    return MD5_R[((r / 16) * 4) + (r % 4)];
  endfunction

  function automatic int md5_g(int r);
    int g;
    if (r < 16) g = r;
    else if (r < 32) g = (5 * r + 1) % 16;
    else if (r < 48) g = (3 * r + 5) % 16;
    else g = (7 * r) % 16;
    return g;
  endfunction

  function automatic logic [31:0] md5_f(int r, logic [31:0] b, logic [31:0] c,
                                        logic [31:0] d);
    logic [31:0] f;
    if (r < 16) f = (b & c) | (~b & d);
    else if (r < 32) f = (d & b) | (~d & c);
    else if (r < 48) f = b ^ c ^ d;
    else f = c ^ (b | ~d);
    return f;
  endfunction

  function automatic logic [7:0] hex_up(logic [3:0] v);
    return (v < 4'd10) ? (8'h30 + {4'd0, v}) : (8'h37 + {4'd0, v});
  endfunction

  // padded 51-byte first message, byte j at bits 8j
  function automatic logic [511:0] msg1(logic [47:0] mac);
    logic [511:0] blk;
    logic [7:0]   bt;
    blk = '0;
    for (int i = 0; i < 6; i++) begin
      bt = mac[8*(5-i) +: 8];
      blk[16*i +: 8]     = (bt < 8'h10) ? 8'h20 : hex_up(bt[7:4]);
      blk[16*i + 8 +: 8] = hex_up(bt[3:0]);
    end
    for (int j = 0; j < 38; j++) blk[8*(12+j) +: 8] = TAIL[8*(37-j) +: 8];
    blk[8*51 +: 8] = 8'h80;
    blk[8*56 +: 8] = 8'h98;
    blk[8*57 +: 8] = 8'h01;
    return blk;
  endfunction

  // padded 13-byte second message from the first digest words a and b
  function automatic logic [511:0] msg2(logic [31:0] a, logic [31:0] b);
    logic [511:0] blk;
    logic [63:0]  h;
    blk = '0;
    h = {b, a};
    for (int i = 0; i < 6; i++) begin
      blk[16*i +: 8]     = 8'h30;
      blk[16*i + 8 +: 8] = hex_up(h[8*i +: 4]);
    end
    blk[8*13 +: 8] = 8'h80;
    blk[8*56 +: 8] = 8'h68;
    return blk;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/mtdp_md5.sv
`timescale 1ns / 1ps
`default_nettype none
module mtdp_md5 (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         en,
  input  wire logic         in_valid,
  input  wire logic [511:0] in_w,
  output logic              out_valid,
  output logic [31:0]       out_a,
  output logic [31:0]       out_b,
  output logic [31:0]       out_c,
  output logic [31:0]       out_d
);

  // one register stage per round; raw state out, IV add done by caller
  logic         sv [mtdp_pkg::ROUNDS+1];
  logic [31:0]  sa [mtdp_pkg::ROUNDS+1];
  logic [31:0]  sb [mtdp_pkg::ROUNDS+1];
  logic [31:0]  sc [mtdp_pkg::ROUNDS+1];
  logic [31:0]  sd [mtdp_pkg::ROUNDS+1];
  logic [511:0] sw [mtdp_pkg::ROUNDS+1];

  assign sv[0] = in_valid;
  assign sa[0] = mtdp_pkg::IV_A;
  assign sb[0] = mtdp_pkg::IV_B;
  assign sc[0] = mtdp_pkg::IV_C;
  assign sd[0] = mtdp_pkg::IV_D;
  assign sw[0] = in_w;

  for (genvar r = 0; r < mtdp_pkg::ROUNDS; r++) begin : g_round
    localparam int S = mtdp_pkg::md5_shift(r);
    localparam int G = mtdp_pkg::md5_g(r);
    logic [31:0] t;
    logic [31:0] rot;

    assign t   = sa[r] + mtdp_pkg::md5_f(r, sb[r], sc[r], sd[r]) + mtdp_pkg::MD5_K[r]
                 + sw[r][32*G +: 32];
    assign rot = (t << S) | (t >> (32 - S));

    always_ff @(posedge clk) begin
      if (rst) begin
        sv[r+1] <= 1'b0;
      end else if (en) begin
        sv[r+1] <= sv[r];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sa[r+1] <= sd[r];
        sd[r+1] <= sc[r];
        sc[r+1] <= sb[r];
        sb[r+1] <= sb[r] + rot;
        sw[r+1] <= sw[r];
      end
    end
  end

  assign out_valid = sv[mtdp_pkg::ROUNDS];
  assign out_a     = sa[mtdp_pkg::ROUNDS];
  assign out_b     = sb[mtdp_pkg::ROUNDS];
  assign out_c     = sc[mtdp_pkg::ROUNDS];
  assign out_d     = sd[mtdp_pkg::ROUNDS];

endmodule
`default_nettype wire

FILE: rtl/core/mac_to_default_passphrase_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Pipeline from request accept to result valid: message build, 64 MD5 rounds,
//   digest add and second message, 64 MD5 rounds, digest add, letters.
// Throughput: one request per cycle; every MD5 round has its own pipeline stage.
// The whole pipeline holds only while a finished result is stalled at the output.
// Reset (rst, synchronous): clears all valid bits; payload registers are not reset.
module mac_to_default_passphrase_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  output logic             req_stall,
  input  wire logic [47:0] mac,
  output logic             rsp_valid,
  input  wire logic        rsp_stall,
  output logic [6:0]       letter_0,
  output logic [6:0]       letter_1,
  output logic [6:0]       letter_2,
  output logic [6:0]       letter_3,
  output logic [6:0]       letter_4,
  output logic [6:0]       letter_5,
  output logic [6:0]       letter_6,
  output logic [6:0]       letter_7,
  output logic [63:0]      digest_hi,
  output logic [63:0]      digest_lo
);

  // global advance: everything moves unless the output holds a stalled result
  logic adv;
  assign adv       = !rsp_valid || !rsp_stall;
  assign req_stall = !adv;

  // stage 0: first message block
  logic         v0;
  logic [511:0] w0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (adv) begin
      v0 <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      w0 <= mtdp_pkg::msg1(mac);
    end
  end

  // first hash
  logic        h1_valid;
  logic [31:0] h1_a, h1_b, h1_c, h1_d;

  mtdp_md5 u_md5_1 (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (v0),
    .in_w      (w0),
    .out_valid (h1_valid),
    .out_a     (h1_a),
    .out_b     (h1_b),
    .out_c     (h1_c),
    .out_d     (h1_d)
  );

  // finish first digest (only a and b feed the second message) and build block 2
  logic         v1;
  logic [511:0] w1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= h1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      w1 <= mtdp_pkg::msg2(h1_a + mtdp_pkg::IV_A, h1_b + mtdp_pkg::IV_B);
    end
  end

  // second hash; h1_c and h1_d are not needed past this point
  logic        h2_valid;
  logic [31:0] h2_a, h2_b, h2_c, h2_d;

  mtdp_md5 u_md5_2 (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (v1),
    .in_w      (w1),
    .out_valid (h2_valid),
    .out_a     (h2_a),
    .out_b     (h2_b),
    .out_c     (h2_c),
    .out_d     (h2_d)
  );

  logic unused_h1;
  assign unused_h1 = ^{h1_c, h1_d};

  // stage: second digest, byte order as in the result fields
  logic        v2;
  logic [31:0] da, db, dc, dd;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= h2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      da <= h2_a + mtdp_pkg::IV_A;
      db <= h2_b + mtdp_pkg::IV_B;
      dc <= h2_c + mtdp_pkg::IV_C;
      dd <= h2_d + mtdp_pkg::IV_D;
    end
  end

  logic [63:0] hi_next, lo_next;
  assign hi_next = {da[7:0], da[15:8], da[23:16], da[31:24],
                    db[7:0], db[15:8], db[23:16], db[31:24]};
  assign lo_next = {dc[7:0], dc[15:8], dc[23:16], dc[31:24],
                    dd[7:0], dd[15:8], dd[23:16], dd[31:24]};

  // letter = 'A' + (hi byte + lo byte) mod 26; quotient by reciprocal
  // 2521/2^16 is exact over 0..510
  logic [6:0] letter_next [8];

  always_comb begin
    logic [8:0]  s;
    logic [20:0] p;
    logic [4:0]  q;
    logic [8:0]  rem;
    for (int i = 0; i < 8; i++) begin
      s   = {1'b0, hi_next[8*i +: 8]} + {1'b0, lo_next[8*i +: 8]};
      p   = {12'd0, s} * 21'd2521;
      q   = p[20:16];
      rem = s - (9'd26 * {4'd0, q});
      letter_next[7-i] = 7'h41 + {2'd0, rem[4:0]};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (adv) begin
      rsp_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      letter_0  <= letter_next[0];
      letter_1  <= letter_next[1];
      letter_2  <= letter_next[2];
      letter_3  <= letter_next[3];
      letter_4  <= letter_next[4];
      letter_5  <= letter_next[5];
      letter_6  <= letter_next[6];
      letter_7  <= letter_next[7];
      digest_hi <= hi_next;
      digest_lo <= lo_next;
    end
  end

`ifndef SYNTH
  a_rst_clears: assert property (@(posedge clk) rst |=> !rsp_valid && !v0 && !v1 && !v2)
    else $error("valid bits not cleared by reset");

  a_letter0_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (letter_0 >= 7'h41) && (letter_0 <= 7'h5A))
    else $error("letter_0 out of range");

  a_letter7_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (letter_7 >= 7'h41) && (letter_7 <= 7'h5A))
    else $error("letter_7 out of range");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |=> ($stable(v2) && $stable(da)))
    else $error("pipeline moved while output stalled");
`endif

endmodule
`default_nettype wire
